FILE: hw/rtl/mfhf_pkg.sv
`timescale 1ns / 1ps

package mfhf_pkg;

  localparam int unsigned LenW  = 28;

  localparam logic [LenW-1:0] LenMax = {LenW{1'b1}};

  // byte kinds
  localparam logic [1:0] KIND_TYPE    = 2'd0;
  localparam logic [1:0] KIND_LENGTH  = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;
  localparam logic [1:0] KIND_DISCARD = 2'd3;

  // error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_TYPE     = 2'd1;
  localparam logic [1:0] ERR_LEN_LONG = 2'd2;
  localparam logic [1:0] ERR_LEN_MAX  = 2'd3;

  // control packet types with fixed flags
  localparam logic [3:0] TYPE_RESERVED_LO = 4'd0;
  localparam logic [3:0] TYPE_RESERVED_HI = 4'd15;
  localparam logic [3:0] TYPE_SUBSCRIBE   = 4'd8;
  localparam logic [3:0] TYPE_UNSUBSCRIBE = 4'd10;
  localparam logic [3:0] FLAGS_SUBSCRIBE  = 4'd2;

endpackage

FILE: hw/rtl/mqtt_fixed_header_framer_unit.sv
`timescale 1ns / 1ps

// MQTT fixed-header framer. Takes one byte per transfer on the input channel and
// gives one result per byte on the output channel: the byte echoed, its kind
// (type, length, payload, or discarded), the held packet type and flags, the
// decoded remaining length, a last-of-packet mark and an error code. Invalid
// types (0, 15, and SUBSCRIBE/UNSUBSCRIBE with flags other than 2), a length
// field longer than four bytes, and a length above the configured length limit
// all flag an error and return the framer to waiting for a type byte. Throughput
// is one byte per clock while the consumer keeps up: the framer state updates and
// the result register loads in the same cycle a byte is accepted, and output
// valid follows in the cycle after the input transfer. The single result register
// is the only buffer; while it is full and the consumer stalls, in_ready_o is low.
// cfg_we_i writes the 28-bit limit and should only be used while no byte is in flight.
module mqtt_fixed_header_framer_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_we_i,
  input  logic [mfhf_pkg::LenW-1:0] cfg_wdata_i,
  // byte input
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                byte_in_i,
  // result output
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [7:0]                byte_out_o,
  output logic [1:0]                byte_kind_o,
  output logic [3:0]                pkt_type_o,
  output logic [3:0]                pkt_flags_o,
  output logic [mfhf_pkg::LenW-1:0] rem_len_o,
  output logic                      last_of_packet_o,
  output logic [1:0]                error_code_o
);

  // framer phases
  localparam logic [1:0] PH_TYPE = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_PAY  = 2'd2;

  // configuration register
  logic [mfhf_pkg::LenW-1:0] max_len_q;

  // framer state
  logic [1:0]                phase_q, phase_d;
  logic [mfhf_pkg::LenW-1:0] accum_q, accum_d;
  logic [1:0]                len_idx_q, len_idx_d;
  logic [mfhf_pkg::LenW-1:0] remain_q, remain_d;
  logic [3:0]                type_q, type_d;
  logic [3:0]                flags_q, flags_d;

  // result register
  logic                      out_valid_q;
  logic [7:0]                byte_q;
  logic [1:0]                kind_q, kind_d;
  logic [mfhf_pkg::LenW-1:0] rlen_q, rlen_d;
  logic                      last_q, last_d;
  logic [1:0]                err_q, err_d;

  logic                      in_xfer;
  logic [mfhf_pkg::LenW-1:0] group_shifted;
  logic [mfhf_pkg::LenW-1:0] accum_new;
  logic [mfhf_pkg::LenW-1:0] remain_dec;
  logic [3:0]                byte_type;
  logic [3:0]                byte_flags;
  logic                      type_ok;

  // result register frees up in the same cycle it is drained
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign byte_type  = byte_in_i[7:4];
  assign byte_flags = byte_in_i[3:0];

  // seven-bit length group placed by its index, least-significant first
  always_comb begin
    case (len_idx_q)
      2'd0:    group_shifted = {{(mfhf_pkg::LenW-7){1'b0}}, byte_in_i[6:0]};
      2'd1:    group_shifted = {{(mfhf_pkg::LenW-14){1'b0}}, byte_in_i[6:0], 7'd0};
      2'd2:    group_shifted = {{(mfhf_pkg::LenW-21){1'b0}}, byte_in_i[6:0], 14'd0};
      default: group_shifted = {byte_in_i[6:0], 21'd0};
    endcase
  end

  assign accum_new  = accum_q | group_shifted;
  assign remain_dec = (remain_q != '0) ?
                      remain_q - {{(mfhf_pkg::LenW-1){1'b0}}, 1'b1} : remain_q;

  always_comb begin
    type_ok = (byte_type != mfhf_pkg::TYPE_RESERVED_LO) &&
              (byte_type != mfhf_pkg::TYPE_RESERVED_HI);
    if (((byte_type == mfhf_pkg::TYPE_SUBSCRIBE) ||
         (byte_type == mfhf_pkg::TYPE_UNSUBSCRIBE)) &&
        (byte_flags != mfhf_pkg::FLAGS_SUBSCRIBE)) begin
      type_ok = 1'b0;
    end
  end

  // next state and result for the byte at the input
  always_comb begin
    phase_d   = phase_q;
    accum_d   = accum_q;
    len_idx_d = len_idx_q;
    remain_d  = remain_q;
    type_d    = type_q;
    flags_d   = flags_q;
    kind_d    = mfhf_pkg::KIND_TYPE;
    rlen_d    = '0;
    last_d    = 1'b0;
    err_d     = mfhf_pkg::ERR_NONE;

    case (phase_q)
      PH_LEN: begin
        accum_d = accum_new;
        if (byte_in_i[7]) begin
          if (len_idx_q == 2'd3) begin
            // continuation on the fourth length byte
            kind_d  = mfhf_pkg::KIND_DISCARD;
            err_d   = mfhf_pkg::ERR_LEN_LONG;
            phase_d = PH_TYPE;
          end else begin
            kind_d    = mfhf_pkg::KIND_LENGTH;
            len_idx_d = len_idx_q + 2'd1;
          end
        end else begin
          rlen_d = accum_new;
          if (accum_new > max_len_q) begin
            kind_d  = mfhf_pkg::KIND_DISCARD;
            err_d   = mfhf_pkg::ERR_LEN_MAX;
            phase_d = PH_TYPE;
          end else if (accum_new == '0) begin
            // empty packet ends on its length byte
            kind_d  = mfhf_pkg::KIND_LENGTH;
            last_d  = 1'b1;
            phase_d = PH_TYPE;
          end else begin
            kind_d   = mfhf_pkg::KIND_LENGTH;
            remain_d = accum_new;
            phase_d  = PH_PAY;
          end
        end
      end
      PH_PAY: begin
        kind_d   = mfhf_pkg::KIND_PAYLOAD;
        rlen_d   = accum_q;
        remain_d = remain_dec;
        if (remain_dec == '0) begin
          last_d  = 1'b1;
          phase_d = PH_TYPE;
        end
      end
      default: begin
        // type byte; unused phase code behaves the same
        type_d  = byte_type;
        flags_d = byte_flags;
        if (type_ok) begin
          kind_d    = mfhf_pkg::KIND_TYPE;
          phase_d   = PH_LEN;
          accum_d   = '0;
          len_idx_d = '0;
          remain_d  = '0;
        end else begin
          kind_d  = mfhf_pkg::KIND_DISCARD;
          err_d   = mfhf_pkg::ERR_TYPE;
          phase_d = PH_TYPE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= mfhf_pkg::LenMax;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_TYPE;
      accum_q   <= '0;
      len_idx_q <= '0;
      remain_q  <= '0;
      type_q    <= '0;
      flags_q   <= '0;
    end else if (in_xfer) begin
      phase_q   <= phase_d;
      accum_q   <= accum_d;
      len_idx_q <= len_idx_d;
      remain_q  <= remain_d;
      type_q    <= type_d;
      flags_q   <= flags_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  // payload of the result register, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      byte_q  <= byte_in_i;
      kind_q  <= kind_d;
      rlen_q  <= rlen_d;
      last_q  <= last_d;
      err_q   <= err_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign byte_out_o       = byte_q;
  assign byte_kind_o      = kind_q;
  assign pkt_type_o       = type_q;
  assign pkt_flags_o      = flags_q;
  assign rem_len_o        = rlen_q;
  assign last_of_packet_o = last_q;
  assign error_code_o     = err_q;

  // an error always comes with a discarded byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (err_q != mfhf_pkg::ERR_NONE) |-> kind_q == mfhf_pkg::KIND_DISCARD)
    else $error("error flagged on a byte not marked discarded");

  // a packet never ends on an error or a type byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && last_q |->
      (err_q == mfhf_pkg::ERR_NONE) &&
      ((kind_q == mfhf_pkg::KIND_LENGTH) || (kind_q == mfhf_pkg::KIND_PAYLOAD)))
    else $error("last_of_packet on an invalid byte");

  // payload phase always has bytes left to pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAY |-> remain_q != '0)
    else $error("payload phase with no bytes remaining");

  // an accepted byte shows up in the result register next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> out_valid_q)
    else $error("accepted byte lost");

  // after a completed packet the framer waits for a type byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && last_d |=> phase_q == PH_TYPE)
    else $error("framer not back to type phase after packet end");

endmodule

FILE: tb/sv/mqtt_fixed_header_framer_unit_test.sv
`timescale 1ns / 1ps

module mqtt_fixed_header_framer_unit_test;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned StallCycles = 300;
  localparam int unsigned BytesPerPhase = 110;

  typedef logic [mfhf_pkg::LenW-1:0] len_t;

  typedef enum logic [1:0] {
    WAIT_TYPE,
    READ_LENGTH,
    PASS_PAYLOAD
  } framer_phase_e;

  typedef struct packed {
    logic [7:0] byte_out;
    logic [1:0] byte_kind;
    logic [3:0] pkt_type;
    logic [3:0] pkt_flags;
    len_t       rem_len;
    logic       last_of_packet;
    logic [1:0] error_code;
  } frame_result_t;

  // clock, reset and everything driven into the framer, all known from time zero
  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  len_t       cfg_wdata = '0;
  logic       in_valid = 1'b0;
  logic [7:0] byte_in = '0;
  logic       out_ready = 1'b0;

  logic            in_ready;
  logic            out_valid;
  frame_result_t   seen;

  // stream bytes waiting to be offered, and results owed by the framer
  logic [7:0]    byte_backlog[$];
  frame_result_t expected_frames[$];

  // knobs set by the sequence in the initial block
  logic send_hold = 1'b0;
  logic steady = 1'b0;
  logic stall_request = 1'b0;

  // receiver hold-off bookkeeping, owned by the output side
  int unsigned hold_cycles = 0;
  logic        hold_done = 1'b0;

  int unsigned   failures = 0;
  int unsigned   cycle_count = 0;
  frame_result_t front_frame;

  // framer state as the predictor sees it, starting from its reset values
  framer_phase_e fr_phase = WAIT_TYPE;
  len_t          fr_accum = '0;
  logic [1:0]    fr_index = '0;
  len_t          fr_left = '0;
  logic [3:0]    fr_type = '0;
  logic [3:0]    fr_flags = '0;
  len_t          fr_limit = mfhf_pkg::LenMax;

  mqtt_fixed_header_framer_unit u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .byte_in_i       (byte_in),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .byte_out_o      (seen.byte_out),
    .byte_kind_o     (seen.byte_kind),
    .pkt_type_o      (seen.pkt_type),
    .pkt_flags_o     (seen.pkt_flags),
    .rem_len_o       (seen.rem_len),
    .last_of_packet_o(seen.last_of_packet),
    .error_code_o    (seen.error_code)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // advance the framer state by one received byte and give the result it owes
  function automatic frame_result_t frame_byte(input logic [7:0] b);
    frame_result_t r;
    logic [1:0]    idx;
    logic          type_ok;
    r = '0;
    r.byte_out = b;
    r.byte_kind = mfhf_pkg::KIND_TYPE;
    r.error_code = mfhf_pkg::ERR_NONE;
    case (fr_phase)
      READ_LENGTH: begin
        // seven value bits per byte, least-significant group first
        idx = fr_index;
        fr_accum = fr_accum | (len_t'(b[6:0]) << (7 * idx));
        if (b[7]) begin
          if (idx == 2'd3) begin
            // fourth byte still says more is coming
            r.byte_kind = mfhf_pkg::KIND_DISCARD;
            r.error_code = mfhf_pkg::ERR_LEN_LONG;
            fr_phase = WAIT_TYPE;
          end else begin
            r.byte_kind = mfhf_pkg::KIND_LENGTH;
            fr_index = idx + 2'd1;
          end
        end else begin
          r.rem_len = fr_accum;
          if (fr_accum > fr_limit) begin
            r.byte_kind = mfhf_pkg::KIND_DISCARD;
            r.error_code = mfhf_pkg::ERR_LEN_MAX;
            fr_phase = WAIT_TYPE;
          end else if (fr_accum == '0) begin
            // empty packet ends on its last length byte
            r.byte_kind = mfhf_pkg::KIND_LENGTH;
            r.last_of_packet = 1'b1;
            fr_phase = WAIT_TYPE;
          end else begin
            r.byte_kind = mfhf_pkg::KIND_LENGTH;
            fr_left = fr_accum;
            fr_phase = PASS_PAYLOAD;
          end
        end
      end
      PASS_PAYLOAD: begin
        r.byte_kind = mfhf_pkg::KIND_PAYLOAD;
        r.rem_len = fr_accum;
        if (fr_left != '0) fr_left = fr_left - len_t'(1);
        if (fr_left == '0) begin
          r.last_of_packet = 1'b1;
          fr_phase = WAIT_TYPE;
        end
      end
      default: begin
        // type byte: latched even when rejected
        fr_type = b[7:4];
        fr_flags = b[3:0];
        type_ok = (fr_type != mfhf_pkg::TYPE_RESERVED_LO) &&
                  (fr_type != mfhf_pkg::TYPE_RESERVED_HI);
        if ((fr_type == mfhf_pkg::TYPE_SUBSCRIBE || fr_type == mfhf_pkg::TYPE_UNSUBSCRIBE) &&
            fr_flags != mfhf_pkg::FLAGS_SUBSCRIBE) begin
          type_ok = 1'b0;
        end
        if (type_ok) begin
          fr_phase = READ_LENGTH;
          fr_accum = '0;
          fr_index = '0;
          fr_left = '0;
        end else begin
          r.byte_kind = mfhf_pkg::KIND_DISCARD;
          r.error_code = mfhf_pkg::ERR_TYPE;
          fr_phase = WAIT_TYPE;
        end
      end
    endcase
    r.pkt_type = fr_type;
    r.pkt_flags = fr_flags;
    return r;
  endfunction

  task automatic compare_field(input string field, input len_t want, input len_t got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      failures++;
    end
  endtask

  // one random packet, a broken one, or line noise, sized for the current limit
  task automatic queue_packet(input len_t limit);
    int unsigned pick;
    int unsigned n_groups;
    int unsigned total;
    logic [3:0]  ptype;
    logic [3:0]  pflags;
    len_t        len;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 4)) byte_backlog.push_back(8'($urandom_range(0, 255)));
    end else begin
      ptype = 4'($urandom_range(1, 14));
      pflags = 4'($urandom_range(0, 15));
      if (pick < 14) begin
        // any type at all, reserved ones and bad subscribe flags included
        ptype = 4'($urandom_range(0, 15));
      end else if (ptype == mfhf_pkg::TYPE_SUBSCRIBE ||
                   ptype == mfhf_pkg::TYPE_UNSUBSCRIBE) begin
        pflags = mfhf_pkg::FLAGS_SUBSCRIBE;
      end
      byte_backlog.push_back({ptype, pflags});
      if (pick < 22) begin
        // length field that never ends
        repeat (4) byte_backlog.push_back(8'($urandom_range(128, 255)));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70) len = len_t'($urandom_range(0, 12));
        else if (pick < 82) len = len_t'($urandom_range(13, 300));
        else if (pick < 92) len = len_t'($urandom());
        else if (limit <= 300) len = limit + len_t'($urandom_range(0, 1));
        else if (limit != mfhf_pkg::LenMax) len = limit + len_t'(1);
        else len = len_t'(12);
        // long payloads only where the limit throws them out
        if (len > 300 && len <= limit) len = len_t'(len % 13);
        if (len < 128) n_groups = 1;
        else if (len < 16384) n_groups = 2;
        else if (len < 2097152) n_groups = 3;
        else n_groups = 4;
        total = n_groups;
        // now and then a padded encoding with extra zero groups
        if ($urandom_range(0, 4) == 0) total = n_groups + $urandom_range(0, 4 - n_groups);
        for (int i = 0; i < total; i++) begin
          byte_backlog.push_back({(i < total - 1) ? 1'b1 : 1'b0, 7'(len >> (7 * i))});
        end
        if (len <= limit) begin
          repeat (len) byte_backlog.push_back(8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  task automatic write_max_length(input len_t value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    fr_limit = value;
    @(negedge clk);
  endtask

  // quiet point: nothing queued, nothing offered, nothing owed
  task automatic drain_framer();
    while (byte_backlog.size() != 0 || in_valid || expected_frames.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  // input side: offer backlog bytes, predict each one on its transfer
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      byte_in <= '0;
    end else begin
      if (in_valid && in_ready) expected_frames.push_back(frame_byte(byte_in));
      if (!in_valid || in_ready) begin
        if (byte_backlog.size() != 0 && !send_hold &&
            (steady || $urandom_range(0, 99) >= 15)) begin
          in_valid <= 1'b1;
          byte_in <= byte_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output side: check each transfer against the oldest owed result
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_frames.size() == 0) begin
          $error("result transfer with no result owed: byte_out 0x%0h", seen.byte_out);
          failures++;
        end else begin
          front_frame = expected_frames.pop_front();
          compare_field("byte_out", len_t'(front_frame.byte_out), len_t'(seen.byte_out));
          compare_field("byte_kind", len_t'(front_frame.byte_kind), len_t'(seen.byte_kind));
          compare_field("pkt_type", len_t'(front_frame.pkt_type), len_t'(seen.pkt_type));
          compare_field("pkt_flags", len_t'(front_frame.pkt_flags),
                        len_t'(seen.pkt_flags));
          compare_field("rem_len", front_frame.rem_len, seen.rem_len);
          compare_field("last_of_packet", len_t'(front_frame.last_of_packet),
                        len_t'(seen.last_of_packet));
          compare_field("error_code", len_t'(front_frame.error_code),
                        len_t'(seen.error_code));
        end
      end
      // one long hold-off so the result register fills and input stalls
      if (stall_request && !hold_done) begin
        out_ready <= 1'b0;
        if (hold_cycles == StallCycles) hold_done <= 1'b1;
        else hold_cycles <= hold_cycles + 1;
      end else begin
        out_ready <= steady || ($urandom_range(0, 99) >= 15);
      end
    end
  end

  // run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    len_t phase_limits[9];
    phase_limits = '{
      len_t'(0), len_t'(1), len_t'(127), len_t'(128), len_t'(16383), len_t'(16384),
      len_t'($urandom()), mfhf_pkg::LenMax, len_t'($urandom_range(2, 300))
    };
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset limit: bad types, bad subscribe flags, empty packet, short payload,
    // and a length field that runs past four bytes
    byte_backlog = '{
      8'h00, 8'hFF, 8'h80,
      8'h82, 8'h00,
      8'hA2, 8'h02, 8'h00, 8'hFF,
      8'h30, 8'hFF, 8'hFF, 8'hFF, 8'hFF
    };
    drain_framer();

    // tight limit: a one-byte payload under the limit, one over, and the largest length
    write_max_length(len_t'(3));
    byte_backlog = '{
      8'h20, 8'h01, 8'h5A,
      8'h20, 8'h04,
      8'h1F, 8'hFF, 8'hFF, 8'hFF, 8'h7F
    };
    drain_framer();

    for (int p = 0; p < 9; p++) begin
      write_max_length(phase_limits[p]);
      steady = (p == 6);
      stall_request = (p == 2);
      while (byte_backlog.size() < BytesPerPhase) queue_packet(fr_limit);
      if (p == 4) begin
        // sender pause mid-stream until the framer has caught up
        while (byte_backlog.size() > BytesPerPhase / 2) @(negedge clk);
        send_hold = 1'b1;
        while (in_valid || expected_frames.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        send_hold = 1'b0;
      end
      drain_framer();
    end

    if (failures == 0 && expected_frames.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
